// ----- sv/dqct_pkg.sv -----
// shared types, constants and index helpers for the dma queue completion tracker
// no dependencies
`default_nettype none

package dqct_pkg;

  localparam int QUEUE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int WRAP_W        = 32;
  localparam int OP_W          = 3;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 104;

  typedef enum logic [OP_W-1:0] {
    OP_SUB_DTX = 3'd0,
    OP_SUB_DRX = 3'd1,
    OP_SUB_ATX = 3'd2,
    OP_SUB_ARX = 3'd3,
    OP_CHK_ATX = 3'd4,
    OP_CHK_ARX = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [IDX_W-1:0]  dtx_tail;
    logic [IDX_W-1:0]  drx_tail;
    logic [IDX_W-1:0]  atx_tail;
    logic [IDX_W-1:0]  arx_tail;
    logic [WRAP_W-1:0] atx_wraps;
    logic [WRAP_W-1:0] arx_wraps;
  } queue_state_t;

  typedef struct packed {
    logic [WRAP_W-1:0] check_wrap;
    logic [IDX_W-1:0]  check_index;
    logic [IDX_W-1:0]  hw_head;
  } item_t;

  typedef struct packed {
    logic [WRAP_W-1:0] wraps_auto_rx;
    logic [WRAP_W-1:0] wraps_auto_tx;
    logic [IDX_W-1:0]  tail_auto_rx;
    logic [IDX_W-1:0]  tail_auto_tx;
    logic [IDX_W-1:0]  tail_direct_rx;
    logic [IDX_W-1:0]  tail_direct_tx;
    logic              queue_empty;
    logic              partial_done;
    logic              accepted;
  } result_t;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] t);
    logic [IDX_W:0] sum;
    sum = {1'b0, t} + (IDX_W+1)'(1);
    next_index = (sum >= (IDX_W+1)'(QUEUE_ENTRIES)) ? '0 : sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/dma_queue_completion_tracker.sv -----
// top level of the dma queue completion tracker: queue state and result register
// depends on dqct_pkg and dqct_step
//
// channel | dir | payload                                    | beat taken when
// s       | in  | tuser opcode, tdata head/index/wrap         | s_tvalid & s_tready
// m       | out | tdata flags, four tails, two wrap counters  | m_tvalid & m_tready
//
// one result beat per input beat, registered: the result is valid in the cycle after its input beat
// sustains one beat per cycle while m_tready stays high; the single result register sets the latency
// s_tready drops only while a result waits and m_tready is low
// rst clears all tails, wrap counters and the result valid
`default_nettype none

module dma_queue_completion_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [dqct_pkg::IN_DATA_W-1:0]     s_tdata,  // hw_head, check_index, check_wrap
  input  wire logic [dqct_pkg::OP_W-1:0]          s_tuser,  // opcode
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // accepted, partial_done, queue_empty, tail_direct_tx, tail_direct_rx,
  // tail_auto_tx, tail_auto_rx, wraps_auto_tx, wraps_auto_rx, zero fill
  output logic [dqct_pkg::OUT_DATA_W-1:0]         m_tdata
);

  localparam int RES_W = $bits(dqct_pkg::result_t);

  dqct_pkg::queue_state_t st, st_next;
  dqct_pkg::result_t      res_next;
  dqct_pkg::item_t        item;
  logic                   s_fire;

  assign item     = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  dqct_step u_step (
    .op   (s_tuser),
    .item (item),
    .cur  (st),
    .nxt  (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        st <= st_next;
      end
      if (s_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {(dqct_pkg::OUT_DATA_W-RES_W)'(0), res_next};
    end
  end

  // full auto tx queue leaves its tail alone
  a_atx_full_hold: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == dqct_pkg::OP_SUB_ATX
      && dqct_pkg::next_index(st.atx_tail) == item.hw_head
    |=> $stable(st.atx_tail) && $stable(st.atx_wraps))
    else $error("auto tx tail moved on a full queue");

  // wrap counters move only as the tail lands on zero
  a_wrap_at_zero: assert property (@(posedge clk) disable iff (rst)
    !$stable(st.atx_wraps) || !$stable(st.arx_wraps)
    |-> (!$stable(st.atx_wraps) ? st.atx_tail == '0 : st.arx_tail == '0))
    else $error("wrap counter moved without tail wrap");

  // a completion flag never comes with a rejection
  a_done_accepted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
    else $error("partial_done set on an unaccepted beat");

endmodule

`default_nettype wire

// ----- sv/dqct_step.sv -----
// next-state and result logic for one beat of the completion tracker
// depends on dqct_pkg
`default_nettype none

module dqct_step (
  input  wire logic                 [dqct_pkg::OP_W-1:0] op,
  input  wire dqct_pkg::item_t                           item,
  input  wire dqct_pkg::queue_state_t                    cur,
  output dqct_pkg::queue_state_t                         nxt,
  output dqct_pkg::result_t                              res
);

  logic [dqct_pkg::IDX_W-1:0]  n_dtx, n_drx, n_atx, n_arx;
  logic [dqct_pkg::WRAP_W-1:0] rec, rec1;
  logic                        acc, done, empty;
  logic [dqct_pkg::IDX_W-1:0]  chk_tail;
  logic [dqct_pkg::WRAP_W-1:0] chk_wraps;
  logic                        chk_done;
  logic [dqct_pkg::IDX_W-1:0]  h, i;

  assign n_dtx = dqct_pkg::next_index(cur.dtx_tail);
  assign n_drx = dqct_pkg::next_index(cur.drx_tail);
  assign n_atx = dqct_pkg::next_index(cur.atx_tail);
  assign n_arx = dqct_pkg::next_index(cur.arx_tail);
  assign rec   = item.check_wrap;
  assign rec1  = item.check_wrap + dqct_pkg::WRAP_W'(1);
  assign h     = item.hw_head;
  assign i     = item.check_index;

  assign chk_tail  = (op == dqct_pkg::OP_CHK_ARX) ? cur.arx_tail : cur.atx_tail;
  assign chk_wraps = (op == dqct_pkg::OP_CHK_ARX) ? cur.arx_wraps : cur.atx_wraps;

  // head passed the recorded index, accounting for one lap of the ring
  always_comb begin
    priority if (h == chk_tail) begin
      chk_done = 1'b1;
    end else if (h < i) begin
      if (chk_tail < i) begin
        chk_done = (chk_tail > h) ? 1'b1 : (chk_wraps != rec1);
      end else begin
        chk_done = (chk_wraps != rec);
      end
    end else if (h == i || chk_tail < i || chk_tail > h) begin
      chk_done = 1'b1;
    end else begin
      chk_done = (chk_wraps != rec);
    end
  end

  always_comb begin
    nxt   = cur;
    acc   = 1'b0;
    done  = 1'b0;
    empty = 1'b0;
    unique case (op)
      dqct_pkg::OP_SUB_DTX: begin
        nxt.dtx_tail = n_dtx;
        acc          = 1'b1;
        empty        = (h == n_dtx);
      end
      dqct_pkg::OP_SUB_DRX: begin
        nxt.drx_tail = n_drx;
        acc          = 1'b1;
        empty        = (h == n_drx);
      end
      dqct_pkg::OP_SUB_ATX: begin
        if (n_atx == h) begin
          empty = (h == cur.atx_tail);
        end else begin
          nxt.atx_tail = n_atx;
          if (n_atx == '0) begin
            nxt.atx_wraps = cur.atx_wraps + dqct_pkg::WRAP_W'(1);
          end
          acc   = 1'b1;
          empty = (h == n_atx);
        end
      end
      dqct_pkg::OP_SUB_ARX: begin
        if (n_arx == h) begin
          empty = (h == cur.arx_tail);
        end else begin
          nxt.arx_tail = n_arx;
          if (n_arx == '0) begin
            nxt.arx_wraps = cur.arx_wraps + dqct_pkg::WRAP_W'(1);
          end
          acc   = 1'b1;
          empty = (h == n_arx);
        end
      end
      dqct_pkg::OP_CHK_ATX, dqct_pkg::OP_CHK_ARX: begin
        acc   = 1'b1;
        done  = chk_done;
        empty = (h == chk_tail);
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.accepted       = acc;
    res.partial_done   = done;
    res.queue_empty    = empty;
    res.tail_direct_tx = nxt.dtx_tail;
    res.tail_direct_rx = nxt.drx_tail;
    res.tail_auto_tx   = nxt.atx_tail;
    res.tail_auto_rx   = nxt.arx_tail;
    res.wraps_auto_tx  = nxt.atx_wraps;
    res.wraps_auto_rx  = nxt.arx_wraps;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for dma_queue_completion_tracker: directed and random command beats
// depends on dqct_pkg and the tracker rtl; tracks tails and wrap counters in its own predictor
`default_nettype none

module tb_top;
  import dqct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int IDLE_PCT = 15;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [OP_W-1:0] op;
    item_t           it;
  } cmd_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [WRAP_W-1:0] wraps;
  } mark_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  cmd_t         pending_cmds[$];
  result_t      due_results[$];
  mark_t        atx_marks[$];
  mark_t        arx_marks[$];
  queue_state_t plan_st = '0;
  queue_state_t live_st = '0;

  int      planned = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  int      mismatches = 0;
  int      rejects = 0;
  int      done_hits = 0;
  result_t accept_res;
  result_t got_res;
  result_t want_res;
  cmd_t    head_cmd;

  dma_queue_completion_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic head_passed_mark(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] tail,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [WRAP_W-1:0] wraps,
                                            input logic [WRAP_W-1:0] rec);
    logic [WRAP_W-1:0] rec_next;
    rec_next = rec + 1'b1;
    if (head == tail) return 1'b1;
    if (head < idx) begin
      if (tail < idx) return (tail > head) ? 1'b1 : (wraps != rec_next);
      return wraps != rec;
    end
    if (head == idx) return 1'b1;
    if (tail < idx || tail > head) return 1'b1;
    return wraps != rec;
  endfunction

  task automatic advance_queues(inout queue_state_t st, input logic [OP_W-1:0] op,
                                input item_t it, output result_t res);
    logic [IDX_W-1:0]  tail_now;
    logic [WRAP_W-1:0] wraps_now;
    logic [IDX_W-1:0]  nxt;
    res = '0;
    case (op)
      OP_SUB_DTX: begin
        st.dtx_tail = st.dtx_tail + 1'b1;
        res.accepted = 1'b1;
        res.queue_empty = (it.hw_head == st.dtx_tail);
      end
      OP_SUB_DRX: begin
        st.drx_tail = st.drx_tail + 1'b1;
        res.accepted = 1'b1;
        res.queue_empty = (it.hw_head == st.drx_tail);
      end
      OP_SUB_ATX, OP_SUB_ARX: begin
        tail_now = (op == OP_SUB_ATX) ? st.atx_tail : st.arx_tail;
        wraps_now = (op == OP_SUB_ATX) ? st.atx_wraps : st.arx_wraps;
        nxt = tail_now + 1'b1;
        if (nxt != it.hw_head) begin
          res.accepted = 1'b1;
          if (nxt == '0) wraps_now = wraps_now + 1'b1;
          tail_now = nxt;
        end
        res.queue_empty = (it.hw_head == tail_now);
        if (op == OP_SUB_ATX) begin
          st.atx_tail = tail_now;
          st.atx_wraps = wraps_now;
        end else begin
          st.arx_tail = tail_now;
          st.arx_wraps = wraps_now;
        end
      end
      OP_CHK_ATX, OP_CHK_ARX: begin
        tail_now = (op == OP_CHK_ATX) ? st.atx_tail : st.arx_tail;
        wraps_now = (op == OP_CHK_ATX) ? st.atx_wraps : st.arx_wraps;
        res.accepted = 1'b1;
        res.partial_done = head_passed_mark(it.hw_head, tail_now, it.check_index,
                                            wraps_now, it.check_wrap);
        res.queue_empty = (it.hw_head == tail_now);
      end
      default: ;
    endcase
    res.tail_direct_tx = st.dtx_tail;
    res.tail_direct_rx = st.drx_tail;
    res.tail_auto_tx = st.atx_tail;
    res.tail_auto_rx = st.arx_tail;
    res.wraps_auto_tx = st.atx_wraps;
    res.wraps_auto_rx = st.arx_wraps;
  endtask

  task automatic add_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] head,
                          input logic [IDX_W-1:0] idx, input logic [WRAP_W-1:0] rec);
    cmd_t    c;
    result_t r;
    mark_t   m;
    c.op = op;
    c.it.hw_head = head;
    c.it.check_index = idx;
    c.it.check_wrap = rec;
    advance_queues(plan_st, op, c.it, r);
    pending_cmds.push_back(c);
    planned++;
    if (r.accepted && op == OP_SUB_ATX) begin
      m.idx = plan_st.atx_tail;
      m.wraps = plan_st.atx_wraps;
      atx_marks.push_back(m);
      if (atx_marks.size() > 32) atx_marks.delete(0);
    end
    if (r.accepted && op == OP_SUB_ARX) begin
      m.idx = plan_st.arx_tail;
      m.wraps = plan_st.arx_wraps;
      arx_marks.push_back(m);
      if (arx_marks.size() > 32) arx_marks.delete(0);
    end
  endtask

  task automatic add_auto_submit(input logic [OP_W-1:0] op, input bit full);
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head;
    tail = (op == OP_SUB_ATX) ? plan_st.atx_tail : plan_st.arx_tail;
    head = full ? tail + 1'b1 : tail - IDX_W'($urandom_range(0, 254));
    add_item(op, head, IDX_W'($urandom), $urandom);
  endtask

  task automatic add_direct_submit(input logic [OP_W-1:0] op);
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head;
    tail = (op == OP_SUB_DTX) ? plan_st.dtx_tail : plan_st.drx_tail;
    head = ($urandom_range(0, 3) == 0) ? tail + 2'd2 : IDX_W'($urandom);
    add_item(op, head, IDX_W'($urandom), $urandom);
  endtask

  task automatic add_check(input logic [OP_W-1:0] op);
    logic [IDX_W-1:0]  tail;
    logic [WRAP_W-1:0] wraps;
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  idx;
    logic [WRAP_W-1:0] rec;
    mark_t             m;
    int                n;
    tail = (op == OP_CHK_ATX) ? plan_st.atx_tail : plan_st.arx_tail;
    wraps = (op == OP_CHK_ATX) ? plan_st.atx_wraps : plan_st.arx_wraps;
    n = (op == OP_CHK_ATX) ? atx_marks.size() : arx_marks.size();
    if (n > 0 && $urandom_range(0, 9) < 7) begin
      m = (op == OP_CHK_ATX) ? atx_marks[n - 1 - $urandom_range(0, (n < 8 ? n : 8) - 1)]
                              : arx_marks[n - 1 - $urandom_range(0, (n < 8 ? n : 8) - 1)];
      idx = m.idx;
      rec = m.wraps;
    end else begin
      idx = IDX_W'($urandom);
      case ($urandom_range(0, 3))
        0: rec = wraps;
        1: rec = wraps - 1'b1;
        2: rec = wraps + 1'b1;
        default: rec = $urandom;
      endcase
    end
    case ($urandom_range(0, 5))
      0: head = tail;
      1: head = idx;
      2: head = idx - 1'b1;
      3: head = idx + 1'b1;
      default: head = IDX_W'($urandom);
    endcase
    add_item(op, head, idx, rec);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge clk);
  endtask

  // driver: predicts on every accepted beat, then offers the next command
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_queues(live_st, s_tuser, item_t'(s_tdata), accept_res);
        due_results.push_back(accept_res);
        beats_in++;
        if (!accept_res.accepted && (s_tuser == OP_SUB_ATX || s_tuser == OP_SUB_ARX))
          rejects++;
        if (accept_res.partial_done) done_hits++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 &&
            ((beats_in >= 200 && beats_in < 320) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          head_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= head_cmd.it;
          s_tuser <= head_cmd.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = result_t'(m_tdata[$bits(result_t)-1:0]);
        beats_out++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat %0d", beats_out);
        end else begin
          want_res = due_results.pop_front();
          if (got_res !== want_res) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d mismatch: exp acc=%0d done=%0d empty=%0d tails=%h/%h/%h/%h wraps=%h/%h",
                       beats_out, want_res.accepted, want_res.partial_done, want_res.queue_empty,
                       want_res.tail_direct_tx, want_res.tail_direct_rx, want_res.tail_auto_tx,
                       want_res.tail_auto_rx, want_res.wraps_auto_tx, want_res.wraps_auto_rx);
              $display("  got acc=%0d done=%0d empty=%0d tails=%h/%h/%h/%h wraps=%h/%h",
                       got_res.accepted, got_res.partial_done, got_res.queue_empty,
                       got_res.tail_direct_tx, got_res.tail_direct_rx, got_res.tail_auto_tx,
                       got_res.tail_auto_rx, got_res.wraps_auto_tx, got_res.wraps_auto_rx);
            end
          end
        end
      end
      m_tready <= (beats_out >= 200 && beats_out < 320) || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  initial begin
    #5_000_000;
    $display("dma_queue_completion_tracker regression: fail");
    $finish;
  end

  initial begin
    int kind;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full auto queues, empty heads, check branches, spare opcodes
    add_item(OP_SUB_ATX, 8'd1, 8'd0, 32'd0);
    add_item(OP_SUB_ARX, 8'd1, 8'hff, 32'hffffffff);
    add_item(OP_CHK_ATX, 8'd0, 8'd0, 32'd0);
    add_item(OP_SUB_DTX, 8'd1, 8'd0, 32'd0);
    add_item(OP_SUB_DRX, 8'hff, 8'hff, 32'hffffffff);
    add_item(OP_SUB_DTX, 8'd0, 8'd0, 32'd0);
    add_item(OP_SUB_ATX, 8'd0, 8'd0, 32'd0);
    add_item(OP_SUB_ARX, 8'hff, 8'd0, 32'd0);
    add_item(OP_CHK_ATX, 8'hff, 8'hff, 32'hffffffff);
    add_item(OP_CHK_ARX, 8'd0, 8'hff, 32'hffffffff);
    add_item(OP_CHK_ARX, 8'd0, 8'd1, 32'd0);
    add_item(OP_CHK_ATX, 8'd1, 8'd0, 32'd0);
    add_item(OP_CHK_ATX, 8'd2, 8'd3, 32'hffffffff);
    add_item(OP_CHK_ATX, 8'd2, 8'd3, 32'd0);
    add_item(OP_CHK_ATX, 8'd5, 8'd0, 32'd0);
    add_item(OP_CHK_ATX, 8'd5, 8'd0, 32'd7);
    add_item(OP_CHK_ARX, 8'd5, 8'd5, 32'd0);
    add_item(OP_SPARE_LO, 8'hff, 8'hff, 32'hffffffff);
    add_item(OP_SPARE_HI, 8'd0, 8'd0, 32'd0);
    add_item(OP_SUB_DRX, 8'd3, 8'd0, 32'd0);
    add_item(OP_SUB_ATX, 8'd2, 8'd0, 32'd0);
    add_item(OP_SUB_DRX, 8'd3, 8'd0, 32'd0);
    wait_drained();

    // long auto tx run so its wrap counter moves
    repeat (320) begin
      kind = $urandom_range(0, 99);
      if (kind < 88) add_auto_submit(OP_SUB_ATX, 1'b0);
      else if (kind < 91) add_auto_submit(OP_SUB_ATX, 1'b1);
      else add_check(OP_CHK_ATX);
    end
    wait_drained();

    // mixed bursts over all queues with some noise
    while (planned < 450) begin
      kind = $urandom_range(0, 19);
      len = $urandom_range(1, 12);
      if (kind < 12) begin
        repeat (len) add_auto_submit(kind < 7 ? OP_SUB_ATX : OP_SUB_ARX,
                                     $urandom_range(0, 9) == 0);
        repeat ($urandom_range(0, 3)) add_check(kind < 7 ? OP_CHK_ATX : OP_CHK_ARX);
      end else if (kind < 16) begin
        repeat (len) add_direct_submit(kind < 14 ? OP_SUB_DTX : OP_SUB_DRX);
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 4)) add_check($urandom_range(0, 1) ? OP_CHK_ATX : OP_CHK_ARX);
      end else begin
        add_item(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end
    end
    wait_drained();

    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d predicted results never arrived", due_results.size());
      mismatches += due_results.size();
    end
    $display("covered %0d command beats, %0d rejected auto submits, %0d partial-done checks",
             beats_in, rejects, done_hits);
    $display("auto wrap counters ended at tx=%0d rx=%0d, %0d mismatches",
             live_st.atx_wraps, live_st.arx_wraps, mismatches);
    if (mismatches == 0) begin
      $display("dma_queue_completion_tracker regression: pass");
    end else begin
      $display("dma_queue_completion_tracker regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/dqct_pkg.sv
sv/dqct_step.sv
sv/dma_queue_completion_tracker.sv
tb/sv/tb_top.sv
